[hw/rtl/rpi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpi_pkg
// Shared types, sizes, codes and the CORDIC angle table of the route
// interpolator.
// ----------------------------------------------------------------------------
package rpi_pkg;

    localparam int MAX_POINTS   = 64;
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_ITERS = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
    localparam int ADDR_W       = $clog2(MAX_POINTS);
    localparam int CNT_W        = $clog2(MAX_POINTS + 1);
    localparam int FRAC_BITS    = 24;

    // register indexes of the configuration port
    localparam logic [1:0] CFG_SPEED       = 2'd0;
    localparam logic [1:0] CFG_MOVE_ENABLE = 2'd1;
    localparam logic [1:0] CFG_NEAR_EPS    = 2'd2;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_MOVE   = 2'd2,
        CMD_SEEK   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_POSITION = 3'd0,
        ST_APPENDED = 3'd1,
        ST_FULL     = 3'd2,
        ST_NONE     = 3'd3,
        ST_CLEARED  = 3'd4
    } status_t;

    // one stored route point
    typedef struct packed {
        logic [31:0]        cum;
        logic signed [31:0] z;
        logic signed [31:0] y;
        logic signed [31:0] x;
    } entry_t;

    // atan(2^-i) in turns, scaled by 2^32
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:    r = 32'd536870912;
            5'd1:    r = 32'd316933406;
            5'd2:    r = 32'd167458907;
            5'd3:    r = 32'd85004756;
            5'd4:    r = 32'd42667331;
            5'd5:    r = 32'd21354465;
            5'd6:    r = 32'd10679838;
            5'd7:    r = 32'd5340245;
            5'd8:    r = 32'd2670163;
            5'd9:    r = 32'd1335087;
            5'd10:   r = 32'd667544;
            5'd11:   r = 32'd333772;
            5'd12:   r = 32'd166886;
            5'd13:   r = 32'd83443;
            5'd14:   r = 32'd41722;
            5'd15:   r = 32'd20861;
            5'd16:   r = 32'd10430;
            5'd17:   r = 32'd5215;
            5'd18:   r = 32'd2608;
            5'd19:   r = 32'd1304;
            5'd20:   r = 32'd652;
            5'd21:   r = 32'd326;
            5'd22:   r = 32'd163;
            5'd23:   r = 32'd81;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/rpi_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpi_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rpi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/polyline_route_interpolator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_route_interpolator
// Route point table with arc-length seek, linear interpolation and heading.
// ----------------------------------------------------------------------------
// Input words arrive on s_* (command in s_tuser), one result word leaves on
// m_* (status in m_tuser) for every input word. Configuration registers are
// to be written through cfg_we / cfg_index / cfg_data only while the block
// is idle; the user must keep to this, the block itself does not enforce it.
// One word is worked on at a time; s_tready is high only in the idle state.
// Multiplies, divisions and square roots share one shift/add unit under a
// sequencer. Clear, a full table and a rejected move/seek go straight to
// the result. Append of a later point squares the three differences and,
// unless their sum overflows, takes a square root. Seek scans the table,
// does a division and three multiplies, then normalizes and runs the CORDIC
// for a heading. Move is a seek after two multiplies and two divisions.
// The scan reads one table entry per cycle from the RAM read port.
// Reset empties the route, zeroes progress and sets near_epsilon to 16.
// A finished result is held in the output register until m_tready; the
// block may accept the next word meanwhile but does not finish it until
// the output register is free.
// ----------------------------------------------------------------------------
module polyline_route_interpolator
    import rpi_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [23:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // point_x, point_y, point_z, delta_time, seek_distance
    input  logic [143:0] s_tdata,
    // command
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // pos_x, pos_y, pos_z, heading, heading_valid, progress, completed, pad
    output logic [135:0] m_tdata,
    // status
    output logic [2:0]   m_tuser
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_EXEC = 10'b0000000010,
        S_MUL  = 10'b0000000100,
        S_DIV  = 10'b0000001000,
        S_SQRT = 10'b0000010000,
        S_SEEK = 10'b0000100000,
        S_SCAN = 10'b0001000000,
        S_NORM = 10'b0010000000,
        S_CORD = 10'b0100000000,
        S_DONE = 10'b1000000000
    } state_t;

    typedef enum logic [14:0] {
        PH_SQX    = 15'b000000000000001,
        PH_SQY    = 15'b000000000000010,
        PH_SQZ    = 15'b000000000000100,
        PH_SQRT   = 15'b000000000001000,
        PH_APPEND = 15'b000000000010000,
        PH_MV0    = 15'b000000000100000,
        PH_MV1    = 15'b000000001000000,
        PH_MV2    = 15'b000000010000000,
        PH_MV3    = 15'b000000100000000,
        PH_MV4    = 15'b000001000000000,
        PH_SKDIV  = 15'b000010000000000,
        PH_SKT    = 15'b000100000000000,
        PH_OFX    = 15'b001000000000000,
        PH_OFY    = 15'b010000000000000,
        PH_OFZ    = 15'b100000000000000
    } phase_t;

    localparam logic [5:0] MUL_LAST  = 6'd31;
    localparam logic [5:0] DIV_LAST  = 6'd63;
    localparam logic [5:0] SQRT_LAST = 6'd31;
    localparam logic [5:0] CORD_LAST = 6'(CORDIC_ITERS - 1);
    localparam logic signed [47:0] NORM_LIM = 48'sh0100_0000_0000;

    function automatic logic signed [32:0] diff33(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        return {a[31], a} - {b[31], b};
    endfunction

    function automatic logic [31:0] mag32(input logic signed [32:0] d);
        logic [32:0] m;
        m = d[32] ? (-d) : d;
        return m[31:0];
    endfunction

    function automatic logic [33:0] abs34(input logic signed [33:0] v);
        return v[33] ? (-v) : v;
    endfunction

    // control state
    state_t        state_reg, state_next;
    phase_t        phase_reg, phase_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]   total_reg, total_next;
    logic [16:0]   progress_reg, progress_next;
    logic          lap_reg, lap_next;
    logic [23:0]   speed_reg, speed_next;
    logic          move_en_reg, move_en_next;
    logic [15:0]   eps_reg, eps_next;
    logic          m_tvalid_reg, m_tvalid_next;

    // datapath
    logic [5:0]    cnt_reg, cnt_next;
    logic [63:0]   acc_reg, acc_next;
    logic [63:0]   opa_reg, opa_next;
    logic [31:0]   opb_reg, opb_next;
    logic [65:0]   sum_reg, sum_next;
    logic signed [31:0] in_x_reg, in_x_next;
    logic signed [31:0] in_y_reg, in_y_next;
    logic signed [31:0] in_z_reg, in_z_next;
    logic [15:0]   delta_reg, delta_next;
    logic [31:0]   d_reg, d_next;
    logic [23:0]   step_reg, step_next;
    logic [33:0]   done_reg, done_next;
    logic [24:0]   t_reg, t_next;
    entry_t        prev_reg, prev_next;
    entry_t        nxt_reg, nxt_next;
    logic signed [33:0] ox_reg, ox_next;
    logic signed [33:0] oy_reg, oy_next;
    logic signed [47:0] cx_reg, cx_next;
    logic signed [47:0] cy_reg, cy_next;
    logic [31:0]   ang_reg, ang_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic signed [31:0] last_x_reg, last_x_next;
    logic signed [31:0] last_y_reg, last_y_next;
    logic signed [31:0] last_z_reg, last_z_next;
    status_t       res_status_reg, res_status_next;
    logic [31:0]   res_x_reg, res_x_next;
    logic [31:0]   res_y_reg, res_y_next;
    logic [31:0]   res_z_reg, res_z_next;
    logic [15:0]   res_head_reg, res_head_next;
    logic          res_hvalid_reg, res_hvalid_next;
    logic [135:0]  m_tdata_reg, m_tdata_next;
    logic [2:0]    m_tuser_reg, m_tuser_next;

    // memory port
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    entry_t            ram_wentry;
    logic [ADDR_W-1:0] ram_raddr;
    logic [$bits(entry_t)-1:0] ram_rdata;
    entry_t            ent;

    // helpers
    logic              accept;
    logic signed [32:0] dpx, dpy, dpz;
    logic [32:0]       q_t;
    logic [32:0]       rem_sh_d;
    logic [33:0]       diff_d;
    logic [35:0]       rem_sh_q;
    logic [35:0]       trial_q;
    logic signed [47:0] xs_c, ys_c;
    logic [65:0]       sum_t;
    logic [32:0]       cum_t;
    logic [41:0]       p_t;
    logic [41:0]       pw_t;
    logic signed [33:0] oz_t;
    logic [31:0]       dd_t;
    logic              near_t;

    rpi_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ent      = entry_t'(ram_rdata);
    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign dpx = diff33(nxt_reg.x, prev_reg.x);
    assign dpy = diff33(nxt_reg.y, prev_reg.y);
    assign dpz = diff33(nxt_reg.z, prev_reg.z);
    assign q_t = acc_reg[56:24];

    assign rem_sh_d = {acc_reg[31:0], opa_reg[63]};
    assign diff_d   = {1'b0, rem_sh_d} - {2'b00, opb_reg};
    assign rem_sh_q = {acc_reg[33:0], opa_reg[63:62]};
    assign trial_q  = {2'b00, opb_reg, 2'b01};
    assign xs_c     = cy_reg >>> cnt_reg[4:0];
    assign ys_c     = cx_reg >>> cnt_reg[4:0];

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        count_next      = count_reg;
        total_next      = total_reg;
        progress_next   = progress_reg;
        lap_next        = lap_reg;
        speed_next      = speed_reg;
        move_en_next    = move_en_reg;
        eps_next        = eps_reg;
        m_tvalid_next   = m_tvalid_reg;
        cnt_next        = cnt_reg;
        acc_next        = acc_reg;
        opa_next        = opa_reg;
        opb_next        = opb_reg;
        sum_next        = sum_reg;
        in_x_next       = in_x_reg;
        in_y_next       = in_y_reg;
        in_z_next       = in_z_reg;
        delta_next      = delta_reg;
        d_next          = d_reg;
        step_next       = step_reg;
        done_next       = done_reg;
        t_next          = t_reg;
        prev_next       = prev_reg;
        nxt_next        = nxt_reg;
        ox_next         = ox_reg;
        oy_next         = oy_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        ang_next        = ang_reg;
        idx_next        = idx_reg;
        last_x_next     = last_x_reg;
        last_y_next     = last_y_reg;
        last_z_next     = last_z_reg;
        res_status_next = res_status_reg;
        res_x_next      = res_x_reg;
        res_y_next      = res_y_reg;
        res_z_next      = res_z_reg;
        res_head_next   = res_head_reg;
        res_hvalid_next = res_hvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        ram_we          = 1'b0;
        ram_waddr       = count_reg[ADDR_W-1:0];
        ram_wentry      = '{cum: 32'd0, z: in_z_reg, y: in_y_reg, x: in_x_reg};
        ram_raddr       = idx_reg + ADDR_W'(1);
        sum_t           = '0;
        cum_t           = '0;
        p_t             = '0;
        pw_t            = '0;
        oz_t            = '0;
        dd_t            = '0;
        near_t          = 1'b0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_SPEED:       speed_next   = cfg_data;
                CFG_MOVE_ENABLE: move_en_next = cfg_data[0];
                CFG_NEAR_EPS:    eps_next     = cfg_data[15:0];
                default:         ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    in_x_next       = s_tdata[31:0];
                    in_y_next       = s_tdata[63:32];
                    in_z_next       = s_tdata[95:64];
                    delta_next      = s_tdata[111:96];
                    res_status_next = ST_NONE;
                    res_x_next      = '0;
                    res_y_next      = '0;
                    res_z_next      = '0;
                    res_head_next   = '0;
                    res_hvalid_next = 1'b0;
                    state_next      = S_DONE;
                    case (cmd_t'(s_tuser))
                        CMD_CLEAR:
                        begin
                            count_next      = '0;
                            total_next      = '0;
                            progress_next   = '0;
                            lap_next        = 1'b0;
                            move_en_next    = 1'b0;
                            res_status_next = ST_CLEARED;
                        end
                        CMD_APPEND:
                        begin
                            if (count_reg >= CNT_W'(MAX_POINTS))
                            begin
                                res_status_next = ST_FULL;
                            end
                            else if (count_reg == '0)
                            begin
                                ram_we          = 1'b1;
                                ram_wentry      = '{cum: 32'd0, z: s_tdata[95:64],
                                                    y: s_tdata[63:32], x: s_tdata[31:0]};
                                count_next      = CNT_W'(1);
                                total_next      = '0;
                                last_x_next     = s_tdata[31:0];
                                last_y_next     = s_tdata[63:32];
                                last_z_next     = s_tdata[95:64];
                                res_status_next = ST_APPENDED;
                            end
                            else
                            begin
                                phase_next = PH_SQX;
                                state_next = S_EXEC;
                            end
                        end
                        CMD_MOVE:
                        begin
                            if (move_en_reg && (total_reg != '0))
                            begin
                                phase_next = PH_MV0;
                                state_next = S_EXEC;
                            end
                        end
                        CMD_SEEK:
                        begin
                            if ((count_reg != '0) && (s_tdata[143:112] <= total_reg))
                            begin
                                d_next     = s_tdata[143:112];
                                state_next = S_SEEK;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_EXEC:
            begin
                // default next step: launch a multiply
                acc_next   = '0;
                cnt_next   = MUL_LAST;
                state_next = S_MUL;
                case (phase_reg)
                    PH_SQX:
                    begin
                        opa_next   = {32'd0, mag32(diff33(in_x_reg, last_x_reg))};
                        opb_next   = mag32(diff33(in_x_reg, last_x_reg));
                        phase_next = PH_SQY;
                    end
                    PH_SQY:
                    begin
                        sum_next   = {2'b00, acc_reg};
                        opa_next   = {32'd0, mag32(diff33(in_y_reg, last_y_reg))};
                        opb_next   = mag32(diff33(in_y_reg, last_y_reg));
                        phase_next = PH_SQZ;
                    end
                    PH_SQZ:
                    begin
                        sum_next   = sum_reg + {2'b00, acc_reg};
                        opa_next   = {32'd0, mag32(diff33(in_z_reg, last_z_reg))};
                        opb_next   = mag32(diff33(in_z_reg, last_z_reg));
                        phase_next = PH_SQRT;
                    end
                    PH_SQRT:
                    begin
                        sum_t      = sum_reg + {2'b00, acc_reg};
                        phase_next = PH_APPEND;
                        if (sum_t[65:64] != 2'b00)
                        begin
                            // saturate the segment length
                            opb_next   = '1;
                            state_next = S_EXEC;
                        end
                        else
                        begin
                            opa_next   = sum_t[63:0];
                            opb_next   = '0;
                            cnt_next   = SQRT_LAST;
                            state_next = S_SQRT;
                        end
                    end
                    PH_APPEND:
                    begin
                        cum_t           = {1'b0, total_reg} + {1'b0, opb_reg};
                        ram_we          = 1'b1;
                        ram_wentry      = '{cum: (cum_t[32] ? 32'hFFFF_FFFF : cum_t[31:0]),
                                            z: in_z_reg, y: in_y_reg, x: in_x_reg};
                        total_next      = cum_t[32] ? 32'hFFFF_FFFF : cum_t[31:0];
                        count_next      = count_reg + CNT_W'(1);
                        last_x_next     = in_x_reg;
                        last_y_next     = in_y_reg;
                        last_z_next     = in_z_reg;
                        res_status_next = ST_APPENDED;
                        state_next      = S_DONE;
                    end
                    PH_MV0:
                    begin
                        opa_next   = {40'd0, speed_reg};
                        opb_next   = {16'd0, delta_reg};
                        phase_next = PH_MV1;
                    end
                    PH_MV1:
                    begin
                        step_next  = acc_reg[39:16];
                        opa_next   = {32'd0, total_reg};
                        opb_next   = {15'd0, progress_reg};
                        phase_next = PH_MV2;
                    end
                    PH_MV2:
                    begin
                        done_next  = {1'b0, acc_reg[48:16]} + {10'd0, step_reg};
                        opa_next   = {24'd0, step_reg, 16'd0};
                        opb_next   = total_reg;
                        cnt_next   = DIV_LAST;
                        state_next = S_DIV;
                        phase_next = PH_MV3;
                    end
                    PH_MV3:
                    begin
                        p_t = {25'd0, progress_reg} + {1'b0, opa_reg[40:0]};
                        if (p_t > 42'd65536)
                        begin
                            // wrap into 1..65536
                            pw_t          = p_t - 42'd1;
                            lap_next      = 1'b1;
                            progress_next = {1'b0, pw_t[15:0]} + 17'd1;
                        end
                        else
                        begin
                            progress_next = p_t[16:0];
                        end
                        opa_next   = {30'd0, done_reg};
                        opb_next   = total_reg;
                        cnt_next   = DIV_LAST;
                        state_next = S_DIV;
                        phase_next = PH_MV4;
                    end
                    PH_MV4:
                    begin
                        d_next     = acc_reg[31:0];
                        state_next = S_SEEK;
                    end
                    PH_SKDIV:
                    begin
                        phase_next = PH_SKT;
                        dd_t       = d_reg - prev_reg.cum;
                        if (nxt_reg.cum > prev_reg.cum)
                        begin
                            opa_next   = {8'd0, dd_t, 24'd0};
                            opb_next   = nxt_reg.cum - prev_reg.cum;
                            cnt_next   = DIV_LAST;
                            state_next = S_DIV;
                        end
                        else
                        begin
                            opa_next   = '0;
                            state_next = S_EXEC;
                        end
                    end
                    PH_SKT:
                    begin
                        t_next     = opa_reg[24:0];
                        opa_next   = {32'd0, mag32(dpx)};
                        opb_next   = {7'd0, opa_reg[24:0]};
                        phase_next = PH_OFX;
                    end
                    PH_OFX:
                    begin
                        ox_next    = dpx[32] ? -$signed({1'b0, q_t}) : $signed({1'b0, q_t});
                        opa_next   = {32'd0, mag32(dpy)};
                        opb_next   = {7'd0, t_reg};
                        phase_next = PH_OFY;
                    end
                    PH_OFY:
                    begin
                        oy_next    = dpy[32] ? -$signed({1'b0, q_t}) : $signed({1'b0, q_t});
                        opa_next   = {32'd0, mag32(dpz)};
                        opb_next   = {7'd0, t_reg};
                        phase_next = PH_OFZ;
                    end
                    PH_OFZ:
                    begin
                        oz_t            = dpz[32] ? -$signed({1'b0, q_t}) : $signed({1'b0, q_t});
                        res_status_next = ST_POSITION;
                        res_x_next      = prev_reg.x + ox_reg[31:0];
                        res_y_next      = prev_reg.y + oy_reg[31:0];
                        res_z_next      = prev_reg.z + oz_t[31:0];
                        near_t          = (abs34(ox_reg) < {18'd0, eps_reg})
                                       && (abs34(oy_reg) < {18'd0, eps_reg})
                                       && (abs34(oz_t) < {18'd0, eps_reg});
                        state_next      = S_DONE;
                        if (!near_t)
                        begin
                            res_hvalid_next = 1'b1;
                            if ((ox_reg == '0) && (oz_t == '0))
                            begin
                                // no direction: plain half turn
                                res_head_next = 16'h8000;
                            end
                            else
                            begin
                                cx_next    = 48'(oz_t);
                                cy_next    = 48'(ox_reg);
                                state_next = S_NORM;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_MUL:
            begin
                if (opb_reg[0])
                begin
                    acc_next = acc_reg + opa_reg;
                end
                opa_next = {opa_reg[62:0], 1'b0};
                opb_next = {1'b0, opb_reg[31:1]};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == '0)
                begin
                    state_next = S_EXEC;
                end
            end

            S_DIV:
            begin
                // restoring division: quotient shifts into opa, remainder in acc
                if (!diff_d[33])
                begin
                    acc_next = {31'd0, diff_d[32:0]};
                end
                else
                begin
                    acc_next = {31'd0, rem_sh_d};
                end
                opa_next = {opa_reg[62:0], ~diff_d[33]};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == '0)
                begin
                    state_next = S_EXEC;
                end
            end

            S_SQRT:
            begin
                if (rem_sh_q >= trial_q)
                begin
                    acc_next = {28'd0, rem_sh_q - trial_q};
                    opb_next = {opb_reg[30:0], 1'b1};
                end
                else
                begin
                    acc_next = {28'd0, rem_sh_q};
                    opb_next = {opb_reg[30:0], 1'b0};
                end
                opa_next = {opa_reg[61:0], 2'b00};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == '0)
                begin
                    state_next = S_EXEC;
                end
            end

            S_SEEK:
            begin
                ram_raddr  = '0;
                idx_next   = '0;
                state_next = S_SCAN;
            end

            S_SCAN:
            begin
                if (idx_reg == '0)
                begin
                    prev_next = ent;
                    if (count_reg == CNT_W'(1))
                    begin
                        nxt_next   = ent;
                        phase_next = PH_SKDIV;
                        state_next = S_EXEC;
                    end
                    else
                    begin
                        idx_next = idx_reg + ADDR_W'(1);
                    end
                end
                else if ((ent.cum >= d_reg) && (prev_reg.cum <= d_reg))
                begin
                    nxt_next   = ent;
                    phase_next = PH_SKDIV;
                    state_next = S_EXEC;
                end
                else
                begin
                    prev_next = ent;
                    idx_next  = idx_reg + ADDR_W'(1);
                end
            end

            S_NORM:
            begin
                if ((cx_reg < NORM_LIM) && (cx_reg > -NORM_LIM)
                    && (cy_reg < NORM_LIM) && (cy_reg > -NORM_LIM))
                begin
                    cx_next = cx_reg <<< 1;
                    cy_next = cy_reg <<< 1;
                end
                else
                begin
                    // fold the left half-plane over
                    if (cx_reg < 0)
                    begin
                        cx_next  = -cx_reg;
                        cy_next  = -cy_reg;
                        ang_next = 32'h8000_0000;
                    end
                    else
                    begin
                        ang_next = '0;
                    end
                    cnt_next   = '0;
                    state_next = S_CORD;
                end
            end

            S_CORD:
            begin
                if (cy_reg >= 0)
                begin
                    cx_next  = cx_reg + xs_c;
                    cy_next  = cy_reg - ys_c;
                    ang_next = ang_reg + atan_turn(cnt_reg[4:0]);
                end
                else
                begin
                    cx_next  = cx_reg - xs_c;
                    cy_next  = cy_reg + ys_c;
                    ang_next = ang_reg - atan_turn(cnt_reg[4:0]);
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == CORD_LAST)
                begin
                    // add a half turn and round to 16 bits
                    res_head_next = 16'((ang_next + 32'h8000_8000) >> 16);
                    state_next    = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'd0, lap_reg, progress_reg, res_hvalid_reg,
                                     res_head_reg, res_z_reg, res_y_reg, res_x_reg};
                    m_tuser_next  = res_status_reg;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            phase_reg    <= PH_SQX;
            count_reg    <= '0;
            total_reg    <= '0;
            progress_reg <= '0;
            lap_reg      <= 1'b0;
            speed_reg    <= '0;
            move_en_reg  <= 1'b0;
            eps_reg      <= 16'd16;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            total_reg    <= total_next;
            progress_reg <= progress_next;
            lap_reg      <= lap_next;
            speed_reg    <= speed_next;
            move_en_reg  <= move_en_next;
            eps_reg      <= eps_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg        <= cnt_next;
        acc_reg        <= acc_next;
        opa_reg        <= opa_next;
        opb_reg        <= opb_next;
        sum_reg        <= sum_next;
        in_x_reg       <= in_x_next;
        in_y_reg       <= in_y_next;
        in_z_reg       <= in_z_next;
        delta_reg      <= delta_next;
        d_reg          <= d_next;
        step_reg       <= step_next;
        done_reg       <= done_next;
        t_reg          <= t_next;
        prev_reg       <= prev_next;
        nxt_reg        <= nxt_next;
        ox_reg         <= ox_next;
        oy_reg         <= oy_next;
        cx_reg         <= cx_next;
        cy_reg         <= cy_next;
        ang_reg        <= ang_next;
        idx_reg        <= idx_next;
        last_x_reg     <= last_x_next;
        last_y_reg     <= last_y_next;
        last_z_reg     <= last_z_next;
        res_status_reg <= res_status_next;
        res_x_reg      <= res_x_next;
        res_y_reg      <= res_y_next;
        res_z_reg      <= res_z_next;
        res_head_reg   <= res_head_next;
        res_hvalid_reg <= res_hvalid_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count above table depth");

    a_progress_range: assert property (@(posedge clk) disable iff (!rst_n)
        progress_reg <= 17'd65536)
        else $error("progress fraction above one");

    a_short_route: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= CNT_W'(1)) |-> (total_reg == '0))
        else $error("route length nonzero with fewer than two points");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word taken while one is in progress");
`endif

endmodule

[tb/polyline_route_interpolator_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_route_interpolator_test
// Self-checking bench for the route interpolator: drives clear, append, move
// and seek words with random gaps and output stalls. It predicts every result
// word with a cycle-free model of the route table and compares field by field.
// ----------------------------------------------------------------------------
module polyline_route_interpolator_test;
    import rpi_pkg::*;

    localparam int          CYCLE_LIMIT = 4000000;
    localparam int          LONG_HOLD   = 3000;
    localparam int          SETTLE      = 600;
    localparam logic [63:0] LEN_SAT     = 64'hFFFF_FFFF;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic [15:0]        heading;
        logic               heading_ok;
        logic [16:0]        progress;
        logic               completed;
    } route_result_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [23:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [143:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;
    logic [2:0]   m_tuser;

    polyline_route_interpolator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // angle of atan(2^-i) in turns scaled by 2^32
    localparam logic [31:0] ANGLE_STEP [16] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861
    };

    // mirror of the block state
    logic signed [31:0] pt_x [MAX_POINTS];
    logic signed [31:0] pt_y [MAX_POINTS];
    logic signed [31:0] pt_z [MAX_POINTS];
    logic [31:0]        pt_len [MAX_POINTS];
    int unsigned        pt_count;
    logic [31:0]        route_len;
    logic [16:0]        lap_frac;
    logic               lap_flag;
    logic [23:0]        reg_speed;
    logic               reg_move_en;
    logic [15:0]        reg_eps;

    route_result_t expected_words[$];
    int  cycle_count;
    int  words_sent;
    int  words_checked;
    int  error_count;
    int  seeks_sent;
    int  moves_sent;
    int  appends_sent;
    bit  quiet;
    bit  gaps_on;
    bit  long_hold_req;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t timeout with %0d words outstanding", $time,
                     expected_words.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic [31:0] root_floor(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 64'd0;
        b   = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res[31:0];
    endfunction

    function automatic logic [31:0] turn_angle(input longint y, input longint x);
        logic [31:0] ang;
        longint      xs;
        longint      ys;
        ang = 32'd0;
        if (x == 0 && y == 0)
            return 32'd0;
        while (mag(x) < (64'sd1 <<< 40) && mag(y) < (64'sd1 <<< 40))
        begin
            x = x * 2;
            y = y * 2;
        end
        if (x < 0)
        begin
            x   = -x;
            y   = -y;
            ang = 32'h8000_0000;
        end
        for (int i = 0; i < 16; i++)
        begin
            xs = y >>> i;
            ys = x >>> i;
            if (y >= 0)
            begin
                x   = x + xs;
                y   = y - ys;
                ang = ang + ANGLE_STEP[i];
            end
            else
            begin
                x   = x - xs;
                y   = y + ys;
                ang = ang - ANGLE_STEP[i];
            end
        end
        return ang;
    endfunction

    function automatic longint lerp_offset(input logic signed [31:0] a,
                                           input logic signed [31:0] b,
                                           input logic [63:0] t);
        longint      dp;
        logic [63:0] q;
        dp = longint'(b) - longint'(a);
        q  = (64'(mag(dp)) * t) >> FRAC_BITS;
        return (dp < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic bit locate(input logic [31:0] d, inout route_result_t r);
        int unsigned prev;
        int unsigned next;
        logic [31:0] c0;
        logic [31:0] c1;
        logic [63:0] t;
        longint      ox;
        longint      oy;
        longint      oz;
        logic [31:0] a;
        longint      eps;
        prev = 0;
        next = 0;
        t    = 64'd0;
        eps  = longint'(reg_eps);
        if (pt_count == 0 || d > route_len)
            return 1'b0;
        for (int unsigned i = 1; i < pt_count; i++)
        begin
            if (pt_len[i] >= d && pt_len[i-1] <= d)
            begin
                prev = i - 1;
                next = i;
                break;
            end
        end
        c0 = pt_len[prev];
        c1 = pt_len[next];
        if (c1 > c0 && d >= c0)
            t = ({32'd0, d - c0} << FRAC_BITS) / {32'd0, c1 - c0};
        ox = lerp_offset(pt_x[prev], pt_x[next], t);
        oy = lerp_offset(pt_y[prev], pt_y[next], t);
        oz = lerp_offset(pt_z[prev], pt_z[next], t);
        r.status = ST_POSITION;
        r.px = 32'(longint'(pt_x[prev]) + ox);
        r.py = 32'(longint'(pt_y[prev]) + oy);
        r.pz = 32'(longint'(pt_z[prev]) + oz);
        if (!(mag(ox) < eps && mag(oy) < eps && mag(oz) < eps))
        begin
            a = turn_angle(ox, oz) + 32'h8000_0000 + 32'h0000_8000;
            r.heading    = a[31:16];
            r.heading_ok = 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic route_result_t predict_route_word(
        input cmd_t cmd, input logic signed [31:0] px, input logic signed [31:0] py,
        input logic signed [31:0] pz, input logic [15:0] dt, input logic [31:0] sd);
        route_result_t r;
        int unsigned   n;
        logic [63:0]   dx, dy, dz, sx, sy, sz, s, s2, c, seg;
        logic [63:0]   step, done, gain, p;
        logic          over;
        logic [31:0]   cum;
        r = '0;
        r.status = ST_NONE;
        case (cmd)
            CMD_CLEAR:
            begin
                pt_count    = 0;
                route_len   = 32'd0;
                lap_frac    = 17'd0;
                lap_flag    = 1'b0;
                reg_move_en = 1'b0;
                r.status    = ST_CLEARED;
            end
            CMD_APPEND:
            begin
                if (pt_count >= MAX_POINTS)
                    r.status = ST_FULL;
                else
                begin
                    n   = pt_count;
                    cum = 32'd0;
                    if (n > 0)
                    begin
                        dx   = 64'(mag(longint'(px) - longint'(pt_x[n-1])));
                        dy   = 64'(mag(longint'(py) - longint'(pt_y[n-1])));
                        dz   = 64'(mag(longint'(pz) - longint'(pt_z[n-1])));
                        sx   = dx * dx;
                        sy   = dy * dy;
                        sz   = dz * dz;
                        s    = sx + sy;
                        over = s < sx;
                        s2   = s + sz;
                        over = over || (s2 < s);
                        seg  = over ? LEN_SAT : {32'd0, root_floor(s2)};
                        c    = {32'd0, pt_len[n-1]} + seg;
                        cum  = (c > LEN_SAT) ? 32'hFFFF_FFFF : c[31:0];
                    end
                    pt_x[n]   = px;
                    pt_y[n]   = py;
                    pt_z[n]   = pz;
                    pt_len[n] = cum;
                    route_len = cum;
                    pt_count  = n + 1;
                    r.status  = ST_APPENDED;
                end
            end
            CMD_MOVE:
            begin
                if (reg_move_en && route_len != 0)
                begin
                    step = ({40'd0, reg_speed} * {48'd0, dt}) >> 16;
                    done = (({47'd0, lap_frac} * {32'd0, route_len}) >> 16) + step;
                    gain = (step << 16) / {32'd0, route_len};
                    p    = {47'd0, lap_frac} + gain;
                    if (p > 64'd65536)
                    begin
                        lap_flag = 1'b1;
                        p = ((p - 64'd1) % 64'd65536) + 64'd1;
                    end
                    lap_frac = p[16:0];
                    done = done % {32'd0, route_len};
                    void'(locate(done[31:0], r));
                end
            end
            default:
                void'(locate(sd, r));
        endcase
        r.progress  = lap_frac;
        r.completed = lap_flag;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------
    task automatic send_word(input cmd_t cmd, input logic [31:0] px,
                             input logic [31:0] py, input logic [31:0] pz,
                             input logic [15:0] dt, input logic [31:0] sd);
        bit rdy;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {sd, dt, pz, py, px};
        forever
        begin
            @(negedge clk);
            rdy = s_tready;
            @(posedge clk);
            if (rdy)
                break;
        end
        expected_words.push_back(predict_route_word(cmd, px, py, pz, dt, sd));
        words_sent++;
        case (cmd)
            CMD_SEEK:   seeks_sent++;
            CMD_MOVE:   moves_sent++;
            CMD_APPEND: appends_sent++;
            default:    ;
        endcase
        if (gaps_on && !quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // unused fields carry random junk so every bit toggles
    task automatic send_cmd(input cmd_t cmd);
        send_word(cmd, $urandom, $urandom, $urandom, 16'($urandom), $urandom);
    endtask

    task automatic send_point(input logic [31:0] px, input logic [31:0] py,
                              input logic [31:0] pz);
        send_word(CMD_APPEND, px, py, pz, 16'($urandom), $urandom);
    endtask

    task automatic send_seek(input logic [31:0] d);
        send_word(CMD_SEEK, $urandom, $urandom, $urandom, 16'($urandom), d);
    endtask

    task automatic send_move(input logic [15:0] dt);
        send_word(CMD_MOVE, $urandom, $urandom, $urandom, dt, $urandom);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_regs(input logic [23:0] spd, input logic en,
                              input logic [15:0] eps);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SPEED;
        cfg_data  <= spd;
        @(posedge clk);
        cfg_index <= CFG_MOVE_ENABLE;
        cfg_data  <= {23'd0, en};
        @(posedge clk);
        cfg_index <= CFG_NEAR_EPS;
        cfg_data  <= {8'd0, eps};
        @(posedge clk);
        cfg_we      <= 1'b0;
        reg_speed   = spd;
        reg_move_en = en;
        reg_eps     = eps;
    endtask

    function automatic logic [31:0] pick_coord(input int mode);
        if (mode == 0)
            return 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
        if (mode == 1)
            return 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_distance();
        int k;
        k = $urandom_range(0, 9);
        if (pt_count == 0 || k == 0)
            return $urandom;
        if (k == 1)
            return route_len + 32'd1;
        if (k == 2)
            return pt_len[$urandom_range(0, pt_count - 1)];
        return $urandom_range(0, route_len);
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t mismatch %s: expected %h actual %h", $time, name,
                     exp_v, act_v);
            error_count++;
        end
    endtask

    initial
    begin
        route_result_t e;
        forever
        begin
            @(negedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t unexpected word: status %h data %h", $time,
                             m_tuser, m_tdata);
                    error_count++;
                end
                else
                begin
                    e = expected_words.pop_front();
                    check_field("status", 32'(e.status), 32'(m_tuser));
                    check_field("pos_x", e.px, m_tdata[31:0]);
                    check_field("pos_y", e.py, m_tdata[63:32]);
                    check_field("pos_z", e.pz, m_tdata[95:64]);
                    check_field("heading", 32'(e.heading), 32'(m_tdata[111:96]));
                    check_field("heading_valid", 32'(e.heading_ok), 32'(m_tdata[112]));
                    check_field("progress", 32'(e.progress), 32'(m_tdata[129:113]));
                    check_field("completed", 32'(e.completed), 32'(m_tdata[130]));
                    words_checked++;
                end
            end
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (gaps_on && !quiet && $urandom_range(0, 9) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_empty_route();
        send_seek(32'd0);
        send_seek(32'hFFFF_FFFF);
        send_move(16'hFFFF);
        wait_idle();
    endtask

    task automatic test_directed_points();
        // single point, then a zero-length segment
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        send_seek(32'd0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        send_seek(32'd0);
        send_cmd(CMD_CLEAR);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_seek(32'hFFFF_FFFF);
        send_cmd(CMD_CLEAR);
        send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_point(32'h0001_0000, 32'h0000_0000, 32'hFFFF_0000);
        send_point(32'hFFFE_0000, 32'h0003_0000, 32'h0002_0000);
        send_seek(32'd0);
        send_seek(route_len);
        send_seek(route_len + 32'd1);
        send_seek(pt_len[1] / 2);
        send_seek(pt_len[1]);
        wait_idle();
        // zero tolerance: zero offset still gets a heading of a half turn
        write_regs(24'hFF_FFFF, 1'b1, 16'd0);
        send_seek(32'd0);
        send_move(16'hFFFF);
        send_move(16'd0);
        wait_idle();
        write_regs(24'd0, 1'b1, 16'hFFFF);
        send_move(16'h8000);
        send_seek(pt_len[1] + 32'd3);
        wait_idle();
    endtask

    task automatic test_full_table();
        send_cmd(CMD_CLEAR);
        for (int i = 0; i < MAX_POINTS + 2; i++)
            send_point(pick_coord(0), pick_coord(0), pick_coord(0));
        for (int i = 0; i < 6; i++)
            send_seek(pick_distance());
        wait_idle();
    endtask

    task automatic run_route_phase(input int ops);
        int mode;
        int k;
        mode = $urandom_range(0, 2);
        send_cmd(CMD_CLEAR);
        wait_idle();
        case ($urandom_range(0, 4))
            0:       write_regs(24'hFF_FFFF, 1'b1, 16'd0);
            1:       write_regs(24'd0, 1'($urandom), 16'hFFFF);
            default: write_regs(24'($urandom), ($urandom_range(0, 5) != 0),
                                16'($urandom_range(0, 64)));
        endcase
        repeat ($urandom_range(2, 20))
            send_point(pick_coord(mode), pick_coord(mode), pick_coord(mode));
        repeat (ops)
        begin
            k = $urandom_range(0, 99);
            if (k < 45)
                send_seek(pick_distance());
            else if (k < 82)
                send_move(16'($urandom));
            else if (k < 92)
                send_point(pick_coord(mode), pick_coord(mode), pick_coord(mode));
            else if (k < 95)
                send_cmd(CMD_CLEAR);
            else
                send_seek($urandom);
        end
    endtask

    task automatic test_random_routes();
        while (words_sent < 950)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            run_route_phase($urandom_range(15, 40));
        end
        gaps_on = 1'b1;
        wait_idle();
    endtask

    task automatic test_output_hold();
        run_route_phase(0);
        wait_idle();
        long_hold_req = 1'b1;
        repeat (10)
            send_seek(pick_distance());
        // sender pauses until everything has drained
        wait_idle();
    endtask

    task automatic test_steady_tail();
        quiet = 1'b1;
        repeat (40)
        begin
            if ($urandom_range(0, 1) == 0)
                send_seek(pick_distance());
            else
                send_move(16'($urandom));
        end
        wait_idle();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_SPEED;
        cfg_data  = 24'd0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_CLEAR;
        cycle_count   = 0;
        words_sent    = 0;
        words_checked = 0;
        error_count   = 0;
        seeks_sent    = 0;
        moves_sent    = 0;
        appends_sent  = 0;
        quiet         = 1'b0;
        gaps_on       = 1'b1;
        long_hold_req = 1'b0;
        pt_count    = 0;
        route_len   = 32'd0;
        lap_frac    = 17'd0;
        lap_flag    = 1'b0;
        reg_speed   = 24'd0;
        reg_move_en = 1'b0;
        reg_eps     = 16'd16;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_route();
        test_directed_points();
        test_full_table();
        test_random_routes();
        test_output_hold();
        test_steady_tail();

        repeat (SETTLE) @(posedge clk);
        $display("Sent %0d words (%0d seeks, %0d moves, %0d appends), checked %0d.",
                 words_sent, seeks_sent, moves_sent, appends_sent, words_checked);
        $display("Covered empty and full tables, zero-length segments, wrap and stalls.");
        if (error_count == 0 && expected_words.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[files.f]
hw/rtl/rpi_pkg.sv
hw/rtl/rpi_ram.sv
hw/rtl/polyline_route_interpolator.sv
tb/polyline_route_interpolator_test.sv
